### sv/prm_pkg.sv
package prm_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int COL_BITS = 2;
  localparam int DIV_STEPS = 4;
  localparam logic [1:0] LAST_COL = 2'd3;
endpackage

### sv/prm_if.sv
interface prm_if #(parameter int W = 32) (input logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/prm_div.sv
module prm_div #(
  parameter int NB = 82,
  parameter int DB = 66,
  parameter int QB = 32,
  parameter int TB = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [TB-1:0] in_tag,
  input  logic [NB-1:0] num [4],
  input  logic [DB-1:0] den,
  output logic          out_valid,
  output logic [TB-1:0] out_tag,
  output logic [QB-1:0] quo [4],
  output logic [3:0]    ovf,
  output logic [3:0]    rnd_up
);
  import prm_pkg::*;
  localparam int NS = QB / DIV_STEPS;
  localparam int RB = DB + 1;
  logic [NS:0] vs;
  logic [TB-1:0] tags [NS+1];
  logic [DB-1:0] dens [NS+1];
  logic [3:0] ovs [NS+1];
  logic [RB-1:0] rs [NS+1][4];
  logic [QB-1:0] qs [NS+1][4];
  logic [RB-1:0] rs_next [NS][4];
  logic [QB-1:0] qs_next [NS][4];

  always_comb begin
    logic [RB-1:0] rt;
    logic [QB-1:0] qt;
    for (int s = 0; s < NS; s++) begin
      for (int l = 0; l < 4; l++) begin
        rt = rs[s][l];
        qt = qs[s][l];
        for (int k = 0; k < DIV_STEPS; k++) begin
          rt = {rt[RB-2:0], qt[QB-1]};
          qt = {qt[QB-2:0], 1'b0};
          if (rt >= {1'b0, dens[s]}) begin
            rt = rt - {1'b0, dens[s]};
            qt[0] = 1'b1;
          end
        end
        rs_next[s][l] = rt;
        qs_next[s][l] = qt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vs <= '0;
    else if (en) vs <= {vs[NS-1:0], in_valid};
    if (en) begin
      tags[0] <= in_tag;
      dens[0] <= den;
      for (int l = 0; l < 4; l++) begin
        rs[0][l] <= RB'(num[l] >> QB);
        qs[0][l] <= num[l][QB-1:0];
        ovs[0][l] <= (num[l] >> QB) >= NB'(den);
      end
      for (int s = 0; s < NS; s++) begin
        tags[s+1] <= tags[s];
        dens[s+1] <= dens[s];
        ovs[s+1] <= ovs[s];
        for (int l = 0; l < 4; l++) begin
          rs[s+1][l] <= rs_next[s][l];
          qs[s+1][l] <= qs_next[s][l];
        end
      end
    end
  end

  assign out_valid = vs[NS];
  assign out_tag = tags[NS];
  assign ovf = ovs[NS];
  always_comb
    for (int l = 0; l < 4; l++) begin
      quo[l] = qs[NS][l];
      rnd_up[l] = {rs[NS][l][RB-2:0], 1'b0} >= {1'b0, dens[NS]};
    end
endmodule

### sv/plane_reflection_matrix.sv
// Reflection matrix of a plane: one plane beat in, four column beats out (column 0 to 3).
// The input is held off by the single result channel while the four columns of a plane are
// issued, one per cycle while the output is not stalled. There are 12 register stages for 32-bit
// words: magnitudes, squared length and products, divider entry with overflow check, eight
// divider stages of four quotient bits each, rounding/saturation. Column 0 passes through them
// in that order after its plane is accepted; a stalled output holds the pipeline.
module plane_reflection_matrix #(
  parameter int WORD_BITS = prm_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = prm_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  prm_if.sink   in_ch,
  prm_if.source out_ch
);
  import prm_pkg::*;
  localparam int W = WORD_BITS;
  localparam int PB = 2 * W + 2;
  localparam int PW = 2 * W;
  localparam int NB = PB + FRAC_BITS;
  localparam int QW = ((W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int TAGB = 4 + COL_BITS + 1;
  localparam logic [QW:0] HALF = (QW+1)'(1) << (W-1);
  logic [W-1:0] mag [4];
  logic [3:0] sgn;
  logic [1:0] col;
  logic busy;
  logic s1v, s2v, s3v;
  logic [W-1:0] m1 [4];
  logic [3:0] sg1;
  logic [1:0] c1;
  logic [PB-1:0] l2;
  logic [PB-1:0] pr [4];
  logic [3:0] ng2;
  logic [1:0] c2;
  logic [QW-1:0] q [4];
  logic [3:0] big;
  logic [3:0] ru;
  logic [3:0] ng3;
  logic [1:0] c3;
  logic zero3;
  logic adv;
  logic [W-1:0] el [4];
  logic [3:0] cl;
  logic ov, ot;
  logic [W*4+COL_BITS+1:0] obuf;
  logic [QW:0] qq;
  logic [TAGB-1:0] tg_in, tg_out;

  assign adv = !ov || out_ch.ready;
  assign in_ch.ready = adv && !busy;
  always_comb
    for (int i = 0; i < 4; i++) begin
      sgn[i] = in_ch.data[W*i+W-1];
      mag[i] = sgn[i] ? W'(-in_ch.data[W*i+:W]) : in_ch.data[W*i+:W];
    end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; col <= '0; s1v <= 1'b0;
    end else if (adv) begin
      if (in_ch.valid && in_ch.ready) begin
        busy <= 1'b1; col <= 2'd1; s1v <= 1'b1;
      end else if (busy) begin
        col <= col + 2'd1; busy <= (col != LAST_COL); s1v <= 1'b1;
      end else begin
        s1v <= 1'b0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv && in_ch.valid && in_ch.ready) begin
      m1 <= mag; sg1 <= sgn;
    end
    if (adv) c1 <= (in_ch.valid && in_ch.ready) ? 2'd0 : col;
  end

  always_ff @(posedge clk) begin
    if (rst) s2v <= 1'b0;
    else if (adv) s2v <= s1v;
    if (adv) begin
      l2 <= PB'(PW'(m1[0]) * PW'(m1[0])) + PB'(PW'(m1[1]) * PW'(m1[1]))
          + PB'(PW'(m1[2]) * PW'(m1[2]));
      for (int i = 0; i < 4; i++) begin
        pr[i] <= PB'(PW'(m1[i]) * PW'(m1[c1])) << 1;
        ng2[i] <= (sg1[i] == sg1[c1]);
      end
      c2 <= c1;
    end
  end

  logic [PB-1:0] dnum [4];
  logic [3:0] dng;
  logic [NB-1:0] dn [4];
  always_comb
    for (int i = 0; i < 4; i++) begin
      if (i == int'(c2)) begin
        dng[i] = pr[i] > l2;
        dnum[i] = dng[i] ? pr[i] - l2 : l2 - pr[i];
      end else begin
        dng[i] = ng2[i];
        dnum[i] = pr[i];
      end
      dn[i] = {dnum[i], {FRAC_BITS{1'b0}}};
    end

  assign tg_in = {dng, c2, l2 == '0};
  prm_div #(.NB(NB), .DB(PB), .QB(QW), .TB(TAGB)) u_div (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(s2v), .in_tag(tg_in),
    .num(dn),
    .den(l2 == '0 ? PB'(1) : l2),
    .out_valid(s3v), .out_tag(tg_out),
    .quo(q), .ovf(big), .rnd_up(ru)
  );
  assign {ng3, c3, zero3} = tg_out;

  always_comb
    for (int i = 0; i < 4; i++) begin
      qq = {1'b0, q[i]} + (QW+1)'(ru[i]);
      cl[i] = 1'b0;
      if (c3 == LAST_COL || zero3) begin
        el[i] = (i == int'(c3)) ? W'(1 << FRAC_BITS) : '0;
      end else if (ng3[i]) begin
        cl[i] = big[i] || (qq > HALF);
        el[i] = cl[i] ? {1'b1, {(W-1){1'b0}}} : W'(-qq);
      end else begin
        cl[i] = big[i] || (qq >= HALF);
        el[i] = cl[i] ? {1'b0, {(W-1){1'b1}}} : qq[W-1:0];
      end
    end

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (adv) ov <= s3v;
    if (adv) obuf <= {c3 == LAST_COL, |cl, el[3], el[2], el[1], el[0], c3};
  end
  assign out_ch.valid = ov;
  assign out_ch.data = obuf;
  assign ot = ov;

  a_col3: assert property (@(posedge clk) disable iff (rst)
    ot |-> (obuf[W*4+COL_BITS+1] == (obuf[1:0] == LAST_COL))) else $error("last flag");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ch.ready) else $error("accept while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (ov && !out_ch.ready) |=> $stable(obuf)) else $error("beat lost");
endmodule

### sim/plane_reflection_matrix_test.sv
`timescale 1ns / 1ps

module plane_reflection_matrix_test;
  import prm_pkg::*;

  localparam int WB = WORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int IN_W = 4 * WB;
  localparam int OUT_W = COL_BITS + 4 * WB + 2;

  typedef logic signed [WB-1:0] word_t;

  typedef struct packed {
    word_t d;
    word_t c;
    word_t b;
    word_t a;
  } plane_t;

  typedef struct packed {
    logic last;
    logic clipped;
    word_t r3;
    word_t r2;
    word_t r1;
    word_t r0;
    logic [COL_BITS-1:0] col;
  } column_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  prm_if #(IN_W) in_bus (clk);
  prm_if #(OUT_W) out_bus (clk);

  plane_reflection_matrix u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_bus),
    .out_ch(out_bus)
  );

  plane_t planes_todo[$];
  column_t columns_due[$];
  int errors = 0;
  int n_sent = 0;
  int n_queued = 0;
  logic in_taken = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  bit calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  function automatic logic [127:0] magnitude(word_t v);
    logic [127:0] m;
    m = {{96{v[WB-1]}}, v};
    if (v[WB-1]) m = -m;
    return m;
  endfunction

  function automatic word_t round_sat(logic [127:0] num, logic [127:0] den, bit neg,
                                      inout bit clip);
    logic [127:0] q;
    logic [127:0] r;
    logic [127:0] lim;
    q = num / den;
    r = num % den;
    if (r >= den - r) q = q + 1;
    lim = 128'd1 << (WB - 1);
    if (!neg) lim = lim - 1;
    if (q > lim) begin
      clip = 1'b1;
      q = lim;
    end
    if (neg) q = -q;
    return q[WB-1:0];
  endfunction

  task automatic reflect_plane(plane_t p);
    logic [127:0] mag[4];
    bit sgn[4];
    logic [127:0] len2;
    logic [127:0] t;
    word_t e[4];
    bit clip;
    column_t col;
    mag[0] = magnitude(p.a); sgn[0] = p.a[WB-1];
    mag[1] = magnitude(p.b); sgn[1] = p.b[WB-1];
    mag[2] = magnitude(p.c); sgn[2] = p.c[WB-1];
    mag[3] = magnitude(p.d); sgn[3] = p.d[WB-1];
    len2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    for (int j = 0; j < 4; j++) begin
      clip = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (j == 3 || len2 == 0) begin
          e[i] = (i == j) ? word_t'(1 << FB) : '0;
        end else if (i == j) begin
          t = (mag[i] * mag[i]) << 1;
          if (t > len2) e[i] = round_sat((t - len2) << FB, len2, 1'b1, clip);
          else e[i] = round_sat((len2 - t) << FB, len2, 1'b0, clip);
        end else begin
          t = (mag[i] * mag[j]) << 1;
          e[i] = round_sat(t << FB, len2, sgn[i] == sgn[j], clip);
        end
      end
      col.col = j[COL_BITS-1:0];
      col.r0 = e[0];
      col.r1 = e[1];
      col.r2 = e[2];
      col.r3 = e[3];
      col.clipped = clip;
      col.last = (j[1:0] == LAST_COL);
      columns_due.push_back(col);
    end
  endtask

  task automatic add_plane(word_t a, word_t b, word_t c, word_t d);
    plane_t p;
    p.a = a; p.b = b; p.c = c; p.d = d;
    planes_todo.push_back(p);
    n_queued++;
  endtask

  function automatic word_t rand_word(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(8 << FB)) - (4 << FB);
      2: return $signed($urandom_range(64)) - 32;
      default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
      in_bus.data <= '0;
      out_bus.ready <= 1'b0;
    end else begin
      if (!in_bus.valid || in_taken) begin
        if (in_gap > 0) begin
          in_bus.valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (planes_todo.size() > 0) begin
          in_bus.valid <= 1'b1;
          in_bus.data <= planes_todo.pop_front();
          in_gap <= pick_gap();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_bus.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_bus.ready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    column_t got;
    column_t want;
    in_taken <= in_bus.valid && in_bus.ready && !rst;
    if (!rst && in_bus.valid && in_bus.ready) begin
      reflect_plane(plane_t'(in_bus.data));
      n_sent++;
    end
    if (!rst && out_bus.valid && out_bus.ready) begin
      got = column_t'(out_bus.data);
      if (columns_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected column beat %h", got);
      end else begin
        want = columns_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("column mismatch: expected col=%0d %h %h %h %h clip=%b last=%b",
                     want.col, want.r0, want.r1, want.r2, want.r3, want.clipped, want.last);
            $display("                 got      col=%0d %h %h %h %h clip=%b last=%b",
                     got.col, got.r0, got.r1, got.r2, got.r3, got.clipped, got.last);
          end
        end
      end
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.data = '0;
    out_bus.ready = 1'b0;
    add_plane(0, 0, 0, 0);
    add_plane(0, 0, 0, 32'sh7fffffff);
    add_plane(1 << FB, 0, 0, 0);
    add_plane(0, 1 << FB, 0, 2 << FB);
    add_plane(0, 0, -(1 << FB), -(3 << FB));
    add_plane(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    add_plane(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_plane(32'sh80000000, 0, 0, 32'sh7fffffff);
    add_plane(1, 0, 0, 32'sh7fffffff);
    add_plane(0, -1, 0, 32'sh80000000);
    add_plane(1, 1, 1, 32'sh80000000);
    add_plane(3 << FB, 4 << FB, 0, 5 << FB);
    add_plane(-(3 << FB), 4 << FB, 12 << FB, -(7 << FB));
    add_plane(1 << FB, 1 << FB, 0, 0);
    add_plane(32'sh7fffffff, 32'sh80000000, 1, -1);
    add_plane(0, 32'sh7fffffff, 32'sh80000000, 0);
    add_plane(2, -3, 5, 32'sh40000000);
    add_plane(32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff, 32'shffff0000);
    for (int k = 0; k < 320; k++) begin
      int ma;
      int md;
      ma = $urandom_range(3);
      md = $urandom_range(3);
      if ($urandom_range(15) == 0)
        add_plane(0, 0, 0, rand_word(md));
      else
        add_plane(rand_word(ma), rand_word($urandom_range(3)), rand_word(ma), rand_word(md));
    end
    repeat (8) @(posedge clk);
    rst = 1'b0;
    fork
      forever begin
        repeat ($urandom_range(200, 40)) @(posedge clk);
        calm = ~calm;
      end
    join_none
    wait (n_sent == n_queued && columns_due.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### plane_reflection_matrix.f
sv/prm_pkg.sv
sv/prm_if.sv
sv/prm_div.sv
sv/plane_reflection_matrix.sv
sim/plane_reflection_matrix_test.sv
